>>> hdl/lprp_pkg.sv
// Shared types and constants of the LRU page frame replacer.
`default_nettype none
package lprp_pkg;

  localparam int NUM_FRAMES_DEF  = 8;
  localparam int STAMP_WIDTH_DEF = 32;
  localparam int PID_W           = 8;
  localparam int PAGE_W          = 8;
  localparam int COUNT_W         = 9;
  localparam int FIU_W           = 4;
  localparam int FRAME_W         = 3;
  localparam int APB_AW          = 3;
  localparam int APB_DW          = 32;

  localparam logic [FIU_W-1:0] FIU_RESET = 4'd8;

  // register index, taken from the word address
  typedef enum logic {
    REG_FRAMES_IN_USE = 1'b0,
    REG_NONE          = 1'b1
  } lprp_reg_t;

  typedef enum logic [1:0] {
    STATUS_HIT     = 2'd0,
    STATUS_FREE    = 2'd1,
    STATUS_EVICT   = 2'd2,
    STATUS_INVALID = 2'd3
  } lprp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } lprp_state_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic write_en;
    logic out_load;
  } lprp_cmd_t;

  typedef struct packed {
    logic invalid;
    logic scan_last;
    logic out_room;
  } lprp_stat_t;

endpackage
`default_nettype wire

>>> hdl/lprp_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lprp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/lprp_ctrl.sv
// Sequencer of the LRU page frame replacer: request intake, scan, write back, result.
`default_nettype none
module lprp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lprp_pkg::lprp_stat_t stat,
  output lprp_pkg::lprp_cmd_t      cmd
);
  import lprp_pkg::*;

  lprp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // a rejected request skips the frame table entirely
        if (stat.invalid) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_en = 1'b1;
          if (stat.scan_last) begin
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        cmd.write_en = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_room) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/lprp_dp.sv
// Datapath: frame table, use counter, scan registers and result register.
`default_nettype none
module lprp_dp #(
  parameter int NUM_FRAMES  = lprp_pkg::NUM_FRAMES_DEF,
  parameter int STAMP_WIDTH = lprp_pkg::STAMP_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lprp_pkg::lprp_cmd_t           cmd,
  output lprp_pkg::lprp_stat_t               stat,
  input  wire logic [lprp_pkg::FIU_W-1:0]    frames_in_use,
  input  wire logic [lprp_pkg::PID_W-1:0]    in_process_id,
  input  wire logic [lprp_pkg::PAGE_W-1:0]   in_page_index,
  input  wire logic [lprp_pkg::COUNT_W-1:0]  in_page_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic [lprp_pkg::FRAME_W-1:0]       out_frame,
  output logic [lprp_pkg::PID_W-1:0]         out_evicted_process,
  output logic [lprp_pkg::PAGE_W-1:0]        out_evicted_page
);
  import lprp_pkg::*;

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);
  localparam int ENT_W = PID_W + PAGE_W + STAMP_WIDTH;

  // request latched at accept
  logic [PID_W-1:0]       pid_r;
  logic [PAGE_W-1:0]      page_r;
  logic                   inv_r;
  logic [CNT_W-1:0]       lim_r, lim_c;

  logic [NUM_FRAMES-1:0]  valid_r;
  logic [STAMP_WIDTH-1:0] cnt_r;

  // scan pipeline
  logic [CNT_W-1:0]       rd_cnt_r;
  logic                   rd_go;
  logic                   chk_vld_r;
  logic [IDX_W-1:0]       chk_idx_r;
  logic [ENT_W-1:0]       rd_data;
  logic [PID_W-1:0]       ent_owner;
  logic [PAGE_W-1:0]      ent_page;
  logic [STAMP_WIDTH-1:0] ent_stamp, age;
  logic                   ent_valid, is_hit, is_free, is_older;

  logic                   hit_found_r, free_found_r;
  logic [IDX_W-1:0]       hit_slot_r, free_slot_r, best_slot_r;
  logic [STAMP_WIDTH-1:0] best_age_r;
  logic [PID_W-1:0]       best_owner_r;
  logic [PAGE_W-1:0]      best_page_r;

  // write back
  logic [IDX_W-1:0]       slot_c;
  lprp_status_t           status_c;
  lprp_status_t           res_status_r;
  logic [FRAME_W-1:0]     res_frame_r;
  logic [PID_W-1:0]       res_ev_owner_r;
  logic [PAGE_W-1:0]      res_ev_page_r;

  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [FRAME_W-1:0]     out_frame_r;
  logic [PID_W-1:0]       out_ev_owner_r;
  logic [PAGE_W-1:0]      out_ev_page_r;

  // clamp the frame limit to 1..NUM_FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      lim_c = CNT_W'(1);
    end else if (int'(frames_in_use) > NUM_FRAMES) begin
      lim_c = CNT_W'(NUM_FRAMES);
    end else begin
      lim_c = CNT_W'(frames_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pid_r  <= in_process_id;
      page_r <= in_page_index;
      inv_r  <= ({1'b0, in_page_index} >= in_page_count);
      lim_r  <= lim_c;
    end
  end

  assign rd_go = cmd.scan_en && (rd_cnt_r < lim_r);

  lprp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.write_en),
    .waddr (slot_c),
    .wdata ({pid_r, page_r, cnt_r}),
    .re    (rd_go),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r  <= '0;
      chk_vld_r <= 1'b0;
    end else if (cmd.load) begin
      rd_cnt_r  <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      chk_vld_r <= rd_go;
      if (rd_go) begin
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      chk_idx_r <= rd_cnt_r[IDX_W-1:0];
    end
  end

  assign ent_owner = rd_data[ENT_W-1 -: PID_W];
  assign ent_page  = rd_data[STAMP_WIDTH +: PAGE_W];
  assign ent_stamp = rd_data[STAMP_WIDTH-1:0];
  assign ent_valid = valid_r[chk_idx_r];
  assign age       = cnt_r - ent_stamp;
  assign is_hit    = ent_valid && (ent_owner == pid_r) && (ent_page == page_r);
  assign is_free   = !ent_valid;
  // oldest stamp wins, lowest frame on ties
  assign is_older  = (chk_idx_r == '0) || (age > best_age_r);

  assign stat.invalid   = inv_r;
  assign stat.scan_last = chk_vld_r && (CNT_W'(chk_idx_r) == lim_r - CNT_W'(1));
  assign stat.out_room  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (chk_vld_r) begin
      if (is_hit && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_slot_r  <= chk_idx_r;
      end
      if (is_free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_slot_r  <= chk_idx_r;
      end
      if (is_older) begin
        best_age_r   <= age;
        best_slot_r  <= chk_idx_r;
        best_owner_r <= ent_owner;
        best_page_r  <= ent_page;
      end
    end
  end

  always_comb begin
    if (hit_found_r) begin
      slot_c   = hit_slot_r;
      status_c = STATUS_HIT;
    end else if (free_found_r) begin
      slot_c   = free_slot_r;
      status_c = STATUS_FREE;
    end else begin
      slot_c   = best_slot_r;
      status_c = STATUS_EVICT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.write_en) begin
      valid_r[slot_c] <= 1'b1;
      cnt_r           <= cnt_r + STAMP_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_en) begin
      res_status_r <= status_c;
      res_frame_r  <= FRAME_W'(slot_c);
      if (status_c == STATUS_EVICT) begin
        res_ev_owner_r <= best_owner_r;
        res_ev_page_r  <= best_page_r;
      end else begin
        res_ev_owner_r <= '0;
        res_ev_page_r  <= '0;
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (inv_r) begin
        out_status_r   <= STATUS_INVALID;
        out_frame_r    <= '0;
        out_ev_owner_r <= '0;
        out_ev_page_r  <= '0;
      end else begin
        out_status_r   <= res_status_r;
        out_frame_r    <= res_frame_r;
        out_ev_owner_r <= res_ev_owner_r;
        out_ev_page_r  <= res_ev_page_r;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_frame           = out_frame_r;
  assign out_evicted_process = out_ev_owner_r;
  assign out_evicted_page    = out_ev_page_r;

endmodule
`default_nettype wire

>>> hdl/lru_page_frame_replacer.sv
// Top level of the LRU page frame replacer: configuration register and core.
//
// Input channel (in_valid/in_ready) takes one page request: process id, page
// index and the process's page count. Result channel (out_valid/out_ready)
// returns status (hit, loaded free, loaded after eviction, invalid), the frame
// and the evicted owner and page.
// One request at a time. With L the frame limit (frames_in_use held to
// 1..NUM_FRAMES), a valid request scans L frame table entries, reading one
// per cycle from the table RAM, whose read is registered; it then writes
// back and loads the result register, which raises out_valid, and the next
// request is taken after that.
// An invalid request (index at or past page count) skips the scan and goes
// straight to loading its result; the next request is taken after that.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls with a result still held, the next request
// finishes its scan and waits before loading its result.
// The APB port holds frames_in_use at address 0; write it only while idle.
// Reset (rst_n low, synchronous) frees all frames, clears the use counter and
// sets frames_in_use to 8; no clearing pass is needed.
`default_nettype none
module lru_page_frame_replacer #(
  parameter int NUM_FRAMES  = lprp_pkg::NUM_FRAMES_DEF,
  parameter int STAMP_WIDTH = lprp_pkg::STAMP_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lprp_pkg::APB_AW-1:0]   paddr,
  input  wire logic [lprp_pkg::APB_DW-1:0]   pwdata,
  output logic      [lprp_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lprp_pkg::PID_W-1:0]    in_process_id,
  input  wire logic [lprp_pkg::PAGE_W-1:0]   in_page_index,
  input  wire logic [lprp_pkg::COUNT_W-1:0]  in_page_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic [lprp_pkg::FRAME_W-1:0]       out_frame,
  output logic [lprp_pkg::PID_W-1:0]         out_evicted_process,
  output logic [lprp_pkg::PAGE_W-1:0]        out_evicted_page
);
  import lprp_pkg::*;

  logic [FIU_W-1:0] fiu_r;
  lprp_reg_t        reg_sel;
  lprp_cmd_t        cmd;
  lprp_stat_t       stat;

  assign reg_sel = lprp_reg_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r <= FIU_RESET;
    end else if (psel && penable && pwrite && (reg_sel == REG_FRAMES_IN_USE)) begin
      fiu_r <= pwdata[FIU_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAMES_IN_USE: prdata = APB_DW'(fiu_r);
      default:           prdata = '0;
    endcase
  end

  lprp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lprp_dp #(
    .NUM_FRAMES  (NUM_FRAMES),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .frames_in_use       (fiu_r),
    .in_process_id       (in_process_id),
    .in_page_index       (in_page_index),
    .in_page_count       (in_page_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_frame           (out_frame),
    .out_evicted_process (out_evicted_process),
    .out_evicted_page    (out_evicted_page)
  );

endmodule
`default_nettype wire

>>> sim/lru_page_frame_replacer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LRU page frame replacer: directed and random page requests.
module lru_page_frame_replacer_tb;
  import lprp_pkg::*;

  localparam int NFRAMES         = NUM_FRAMES_DEF;
  localparam int STAMP_W         = STAMP_WIDTH_DEF;
  localparam int SETTLE_CYCLES   = 16;
  localparam int ITEMS_PER_PHASE = 140;
  localparam logic [APB_AW-1:0] FIU_ADDR = APB_AW'(4 * int'(REG_FRAMES_IN_USE));

  typedef struct packed {
    lprp_status_t       status;
    logic [FRAME_W-1:0] frame;
    logic [PID_W-1:0]   ev_pid;
    logic [PAGE_W-1:0]  ev_page;
  } ref_outcome_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [PID_W-1:0]    in_process_id = '0;
  logic [PAGE_W-1:0]   in_page_index = '0;
  logic [COUNT_W-1:0]  in_page_count = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_status;
  logic [FRAME_W-1:0]  out_frame;
  logic [PID_W-1:0]    out_evicted_process;
  logic [PAGE_W-1:0]   out_evicted_page;

  // shadow of the frame table and the limit register
  bit                  tbl_valid [NFRAMES] = '{default: 1'b0};
  logic [PID_W-1:0]    tbl_owner [NFRAMES] = '{default: '0};
  logic [PAGE_W-1:0]   tbl_page  [NFRAMES] = '{default: '0};
  logic [STAMP_W-1:0]  tbl_stamp [NFRAMES] = '{default: '0};
  logic [STAMP_W-1:0]  use_clock = '0;
  logic [FIU_W-1:0]    frame_limit = FIU_RESET;

  ref_outcome_t        pending_outcomes [$];
  int                  err_count = 0;
  bit                  no_idle = 1'b0;

  lru_page_frame_replacer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_process_id       (in_process_id),
    .in_page_index       (in_page_index),
    .in_page_count       (in_page_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_frame           (out_frame),
    .out_evicted_process (out_evicted_process),
    .out_evicted_page    (out_evicted_page)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("** lru_page_frame_replacer: FAILED **");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Apply one page request to the shadow table and return the outcome.
  function automatic ref_outcome_t resolve_reference(input logic [PID_W-1:0] pid,
                                                     input logic [PAGE_W-1:0] page,
                                                     input logic [COUNT_W-1:0] count);
    ref_outcome_t        res;
    int                  lim;
    int                  slot;
    int                  i;
    bit                  found;
    logic [STAMP_W-1:0]  age;
    logic [STAMP_W-1:0]  oldest;
    res = '{STATUS_INVALID, '0, '0, '0};
    if ({1'b0, page} >= count) return res;
    lim = (frame_limit == 0) ? 1 : (frame_limit > NFRAMES) ? NFRAMES : int'(frame_limit);
    found = 1'b0;
    slot = 0;
    oldest = '0;
    for (i = 0; i < lim && !found; i++) begin
      if (tbl_valid[i] && tbl_owner[i] == pid && tbl_page[i] == page) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      res.status = STATUS_HIT;
    end else begin
      for (i = 0; i < lim && !found; i++) begin
        if (!tbl_valid[i]) begin
          slot = i;
          found = 1'b1;
        end
      end
      if (found) begin
        res.status = STATUS_FREE;
      end else begin
        // oldest by wrapped age, lowest frame on ties
        for (i = 0; i < lim; i++) begin
          age = use_clock - tbl_stamp[i];
          if (i == 0 || age > oldest) begin
            oldest = age;
            slot = i;
          end
        end
        res.status  = STATUS_EVICT;
        res.ev_pid  = tbl_owner[slot];
        res.ev_page = tbl_page[slot];
      end
      tbl_valid[slot] = 1'b1;
      tbl_owner[slot] = pid;
      tbl_page[slot]  = page;
    end
    tbl_stamp[slot] = use_clock;
    use_clock       = use_clock + 1'b1;
    res.frame       = FRAME_W'(slot);
    return res;
  endfunction

  always @(posedge clk) out_ready <= no_idle || ($urandom_range(99) >= 31);

  always @(posedge clk) begin
    ref_outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch($sformatf("result with no request outstanding: status %0d frame %0d",
                                out_status, out_frame));
      end else begin
        want = pending_outcomes.pop_front();
        if (out_status !== want.status || out_frame !== want.frame ||
            out_evicted_process !== want.ev_pid || out_evicted_page !== want.ev_page)
          note_mismatch($sformatf(
            "result mismatch: exp st %0d fr %0d ev %0d/%0d, got st %0d fr %0d ev %0d/%0d",
            want.status, want.frame, want.ev_pid, want.ev_page,
            out_status, out_frame, out_evicted_process, out_evicted_page));
      end
    end
  end

  task automatic send_reference(input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] page,
                                input logic [COUNT_W-1:0] count);
    while (!no_idle && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_process_id <= pid;
    in_page_index <= page;
    in_page_count <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_outcomes.push_back(resolve_reference(pid, page, count));
  endtask

  // Hold the sender until every result is back, then let the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_frame_limit();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= FIU_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[FIU_W-1:0] !== frame_limit)
      note_mismatch($sformatf("frames_in_use readback: exp %0d got %0d",
                              frame_limit, prdata[FIU_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_frame_limit(input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FIU_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel        <= 1'b0;
    penable     <= 1'b0;
    frame_limit = value[FIU_W-1:0];
    @(posedge clk);
    check_frame_limit();
  endtask

  task automatic test_invalid_references();
    send_reference(8'h00, 8'h00, 9'd0);
    send_reference(8'hFF, 8'hFF, 9'd255);
    send_reference(8'hAA, 8'd200, 9'd100);
    drain_results();
  endtask

  task automatic test_fill_and_hit();
    int i;
    send_reference(8'h00, 8'h00, 9'd1);
    send_reference(8'hFF, 8'hFF, 9'd256);
    for (i = 1; i <= 6; i++) send_reference(PID_W'(i), PAGE_W'(i), 9'h1FF);
    send_reference(8'hFF, 8'hFF, 9'd256);
    send_reference(8'h00, 8'h00, 9'd1);
  endtask

  task automatic test_lru_eviction();
    send_reference(8'd7, 8'd7, 9'd8);
    send_reference(8'd1, 8'd1, 9'd2);
    drain_results();
  endtask

  task automatic test_limit_extremes();
    // zero acts as one frame
    write_frame_limit(32'd0);
    send_reference(8'd9, 8'd9, 9'd10);
    send_reference(8'd0, 8'd0, 9'd1);
    drain_results();
    // values above the frame count act as all frames
    write_frame_limit(32'hFFFF_FFFF);
    send_reference(8'd9, 8'd9, 9'd10);
    drain_results();
  endtask

  task automatic test_duplicate_residency();
    write_frame_limit(32'd1);
    send_reference(8'd20, 8'd1, 9'd2);
    drain_results();
    write_frame_limit(32'd2);
    send_reference(8'd21, 8'd2, 9'd3);
    drain_results();
    write_frame_limit(32'd1);
    send_reference(8'd21, 8'd2, 9'd3);
    drain_results();
    // same page now sits in two frames; the lower one must hit
    write_frame_limit(32'd2);
    send_reference(8'd21, 8'd2, 9'd3);
    send_reference(8'd22, 8'd5, 9'd6);
    drain_results();
  endtask

  task automatic send_random_reference(input int pid_span, input int page_span);
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [COUNT_W-1:0] count;
    int                 pick;
    pick = $urandom_range(99);
    if (pick < 72) begin
      pid  = PID_W'($urandom_range(pid_span - 1));
      page = PAGE_W'($urandom_range(page_span - 1));
      if ($urandom_range(7) == 0) pid = ~pid;
      if ($urandom_range(7) == 0) page = ~page;
      count = COUNT_W'($urandom_range(256, int'(page) + 1));
    end else if (pick < 84) begin
      pid   = PID_W'($urandom);
      page  = PAGE_W'($urandom);
      count = COUNT_W'($urandom);
    end else if (pick < 96) begin
      pid   = PID_W'($urandom_range(pid_span - 1));
      page  = PAGE_W'($urandom);
      count = COUNT_W'($urandom_range(int'(page)));
    end else begin
      pid   = 8'hFF;
      page  = 8'hFF;
      count = $urandom_range(1) ? 9'd256 : 9'h1FF;
    end
    send_reference(pid, page, count);
  endtask

  task automatic test_random_phases();
    int                limits [12] = '{8, 1, 4, 0, 15, 2, 6, 8, 3, 9, 5, 7};
    int                ph;
    int                n;
    int                pid_span;
    int                page_span;
    logic [APB_DW-1:0] value;
    for (ph = 0; ph < 12; ph++) begin
      value = $urandom;
      value[FIU_W-1:0] = FIU_W'(limits[ph]);
      write_frame_limit(value);
      pid_span  = $urandom_range(3, 1);
      page_span = $urandom_range(6, 2);
      no_idle   = (ph == 7);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 4 && n == ITEMS_PER_PHASE / 2) drain_results();
        send_random_reference(pid_span, page_span);
      end
      drain_results();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_frame_limit();
    test_invalid_references();
    test_fill_and_hit();
    test_lru_eviction();
    test_limit_extremes();
    test_duplicate_residency();
    test_random_phases();
    drain_results();
    if (err_count == 0 && pending_outcomes.size() == 0) begin
      $display("** lru_page_frame_replacer: PASSED **");
    end else begin
      $display("** lru_page_frame_replacer: FAILED **");
    end
    $finish;
  end

endmodule
